[hw/rtl/mbag_pkg.sv]
`timescale 1ns / 1ps

package mbag_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int ITEM_W      = 32;
   localparam int OPCODE_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = 1;
   localparam int QFILL_W     = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_COUNT  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   scan;
      logic [VALUE_WIDTH-1:0] value;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_LAST,
      BK_DONE
   } bk_state_type;

endpackage

[hw/rtl/mbag_front.sv]
`timescale 1ns / 1ps

module mbag_front
   import mbag_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ITEM_W-1:0]   req_item_value,
   output job_type             head_job,
   output logic                q_empty,
   input  logic                q_pop
);

   job_type              q_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff;
   logic [QFILL_W-1:0]   fill_in;
   logic                 push;
   logic                 pop;
   job_type              new_job;

   always_comb begin
      new_job.op    = op_type'(req_opcode);
      new_job.scan  = (op_type'(req_opcode) != OP_CLEAR);
      new_job.value = req_item_value[VALUE_WIDTH-1:0];
   end

   assign busy     = (fill_ff == QFILL_W'(QDEPTH));
   assign q_empty  = (fill_ff == '0);
   assign push     = start && !busy;
   assign pop      = q_pop && !q_empty;
   assign head_job = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

[hw/rtl/mbag_back.sv]
`timescale 1ns / 1ps

module mbag_back
   import mbag_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  job_type            head_job,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic [COUNT_W-1:0] rsp_match_count,
   output logic [COUNT_W-1:0] rsp_size_now
);

   bk_state_type           state_ff;
   bk_state_type           state_in;

   logic [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [IDX_W-1:0]       cmp_idx_ff;
   logic                   cmp_vld_ff;

   job_type                job_ff;
   logic [COUNT_W-1:0]     match_cnt_ff;
   logic                   hit_found_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;

   logic [DEPTH-1:0]       valid_ff;
   logic [DEPTH-1:0]       valid_in;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;

   logic                   strobe_ff;
   logic                   ok_ff;
   logic                   ok_in;
   logic [COUNT_W-1:0]     match_ff;
   logic [COUNT_W-1:0]     match_in;
   logic [COUNT_W-1:0]     size_ff;

   logic                   pop;
   logic                   issue;
   logic                   finish;
   logic                   mem_we;
   logic                   hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      issue    = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               state_in = head_job.scan ? BK_SCAN : BK_DONE;
            end
         end
         BK_SCAN: begin
            issue = 1'b1;
            if (rd_idx_ff == IDX_W'(DEPTH - 1)) begin
               state_in = BK_LAST;
            end
         end
         BK_LAST: begin
            state_in = BK_DONE;
         end
         BK_DONE: begin
            finish   = 1'b1;
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign q_pop = pop;
   assign hit   = valid_ff[cmp_idx_ff] && (rdata_ff == job_ff.value);

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      match_in = '0;
      mem_we   = 1'b0;
      if (finish) begin
         unique case (job_ff.op)
            OP_ADD: begin
               if (free_found_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + 1'b1;
                  ok_in                 = 1'b1;
                  mem_we                = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (hit_found_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  count_in             = count_ff - 1'b1;
                  ok_in                = 1'b1;
               end
            end
            OP_COUNT: begin
               match_in = match_cnt_ff;
               ok_in    = (match_cnt_ff != '0);
            end
            OP_CLEAR: begin
               valid_in = '0;
               count_in = '0;
               ok_in    = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[rd_idx_ff];
      if (mem_we) begin
         mem_ff[free_idx_ff] <= job_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         count_ff   <= '0;
         strobe_ff  <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         strobe_ff  <= finish;
         cmp_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_idx_ff;
      if (pop) begin
         job_ff        <= head_job;
         rd_idx_ff     <= '0;
         match_cnt_ff  <= '0;
         hit_found_ff  <= 1'b0;
         hit_idx_ff    <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
      end else begin
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (cmp_vld_ff) begin
            if (hit) begin
               match_cnt_ff <= match_cnt_ff + 1'b1;
               if (!hit_found_ff) begin
                  hit_found_ff <= 1'b1;
                  hit_idx_ff   <= cmp_idx_ff;
               end
            end
            if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= cmp_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         ok_ff    <= ok_in;
         match_ff <= match_in;
         size_ff  <= count_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_match_count = match_ff;
   assign rsp_size_now    = size_ff;

endmodule

[hw/rtl/multiset_bag_store.sv]
// The back end picks up each request from the queue; for add, remove and count it reads
//   the 16 slots one at a time through the single read port of the value memory, then
//   finishes and registers the result on rsp_strobe; clear skips the slot reads.
// It takes no new request before it is done with the last; the queue holds up to two.
// Reset (synchronous): empties the request queue, marks every slot empty, clears the size.
`timescale 1ns / 1ps

module multiset_bag_store
   import mbag_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ITEM_W-1:0]   req_item_value,
   output logic                rsp_strobe,
   output logic                rsp_ok,
   output logic [COUNT_W-1:0]  rsp_match_count,
   output logic [COUNT_W-1:0]  rsp_size_now
);

   job_type head_job;
   logic    q_empty;
   logic    q_pop;

   mbag_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_item_value (req_item_value),
      .head_job       (head_job),
      .q_empty        (q_empty),
      .q_pop          (q_pop)
   );

   mbag_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_match_count (rsp_match_count),
      .rsp_size_now    (rsp_size_now)
   );

`ifndef SYNTHESIS
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty request queue");

   a_pop_spaced: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop)
      else $error("back end took two requests in a row");

   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_size_now <= COUNT_W'(DEPTH)))
      else $error("size above store depth");

   a_match_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_match_count != '0)) |-> rsp_ok)
      else $error("nonzero match count without ok");
`endif

endmodule

[sim/multiset_bag_store_tb.sv]
`timescale 1ns / 1ps

module multiset_bag_store_tb;
   import mbag_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int RANDOM_REQS = 1450;

   typedef struct {
      op_type          op;
      logic [ITEM_W-1:0] value;
      int              gap;
      bit              drain;
   } bag_request;

   typedef struct {
      logic               ok;
      logic [COUNT_W-1:0] match_count;
      logic [COUNT_W-1:0] size_now;
   } bag_result;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode = OP_ADD;
   logic [ITEM_W-1:0]   req_item_value = '0;
   logic                rsp_strobe;
   logic                rsp_ok;
   logic [COUNT_W-1:0]  rsp_match_count;
   logic [COUNT_W-1:0]  rsp_size_now;

   bag_request req_backlog[$];
   bag_result  awaited_results[$];

   logic [VALUE_WIDTH-1:0] bag_val[DEPTH];
   bit                     bag_used[DEPTH];
   int                     bag_fill;

   bit req_taken = 1'b0;
   int idle_left = 0;
   int total_reqs = 0;
   int accepted = 0;
   int errors = 0;
   int cycles = 0;
   int n_add = 0, n_add_full = 0, n_remove = 0, n_remove_miss = 0;
   int n_count = 0, n_count_hit = 0, n_clear = 0, n_full_seen = 0;

   multiset_bag_store dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_match_count (rsp_match_count),
      .rsp_size_now    (rsp_size_now)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   function automatic bag_result bag_apply(input op_type op, input logic [ITEM_W-1:0] raw);
      bag_result r;
      logic [VALUE_WIDTH-1:0] v;
      int hits;
      v = raw[VALUE_WIDTH-1:0];
      r.ok = 1'b0;
      r.match_count = '0;
      hits = 0;
      case (op)
         OP_ADD: begin
            n_add++;
            for (int i = 0; i < DEPTH; i++) begin
               if (!bag_used[i]) begin
                  bag_used[i] = 1'b1;
                  bag_val[i] = v;
                  bag_fill++;
                  r.ok = 1'b1;
                  break;
               end
            end
            if (!r.ok) n_add_full++;
            if (bag_fill == DEPTH) n_full_seen++;
         end
         OP_REMOVE: begin
            n_remove++;
            for (int i = 0; i < DEPTH; i++) begin
               if (bag_used[i] && bag_val[i] == v) begin
                  bag_used[i] = 1'b0;
                  bag_fill--;
                  r.ok = 1'b1;
                  break;
               end
            end
            if (!r.ok) n_remove_miss++;
         end
         OP_COUNT: begin
            n_count++;
            for (int i = 0; i < DEPTH; i++)
               if (bag_used[i] && bag_val[i] == v) hits++;
            r.match_count = hits[COUNT_W-1:0];
            r.ok = (hits > 0);
            if (r.ok) n_count_hit++;
         end
         default: begin
            n_clear++;
            for (int i = 0; i < DEPTH; i++) bag_used[i] = 1'b0;
            bag_fill = 0;
            r.ok = 1'b1;
         end
      endcase
      r.size_now = bag_fill[COUNT_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 24);
      return $urandom_range(30, 90);
   endfunction

   task automatic queue_request(input op_type op, input logic [ITEM_W-1:0] value,
                                input int gap, input bit drain);
      bag_request q;
      q.op = op;
      q.value = value;
      q.gap = gap;
      q.drain = drain;
      req_backlog.push_back(q);
      total_reqs++;
   endtask

   // driver: hold a request until taken, then idle for its gap
   always @(negedge clock) begin : driver
      bag_request nxt;
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else if (!start || req_taken) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
         end else if (req_backlog.size() > 0 &&
                      !(req_backlog[0].drain && awaited_results.size() > 0)) begin
            nxt = req_backlog.pop_front();
            start <= 1'b1;
            req_opcode <= nxt.op;
            req_item_value <= nxt.value;
            idle_left <= nxt.gap;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results first, then record the request taken at this edge
   always @(posedge clock) begin : monitor
      bag_result want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ok !== want.ok)
                  report_mismatch($sformatf("ok %b, want %b", rsp_ok, want.ok));
               if (rsp_match_count !== want.match_count)
                  report_mismatch($sformatf("match_count %0d, want %0d",
                                            rsp_match_count, want.match_count));
               if (rsp_size_now !== want.size_now)
                  report_mismatch($sformatf("size_now %0d, want %0d",
                                            rsp_size_now, want.size_now));
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            awaited_results.push_back(bag_apply(op_type'(req_opcode), req_item_value));
            accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [ITEM_W-1:0] pool[8];
      int pool_n, phase_len, add_w, r, gap;
      bit quiet;
      op_type op;
      logic [ITEM_W-1:0] v;

      bag_fill = 0;
      for (int i = 0; i < DEPTH; i++) begin
         bag_used[i] = 1'b0;
         bag_val[i] = '0;
      end

      queue_request(OP_CLEAR, $urandom(), pick_gap(), 1'b0);
      queue_request(OP_REMOVE, 32'h0000_0000, pick_gap(), 1'b0);
      queue_request(OP_COUNT, 32'h0000_0000, pick_gap(), 1'b0);
      queue_request(OP_ADD, 32'hFFFF_FFFF, pick_gap(), 1'b0);
      queue_request(OP_ADD, 32'h0000_0000, pick_gap(), 1'b0);
      queue_request(OP_ADD, 32'hFFFF_FFFF, pick_gap(), 1'b0);
      queue_request(OP_COUNT, 32'hFFFF_FFFF, pick_gap(), 1'b0);
      queue_request(OP_REMOVE, 32'hFFFF_FFFF, pick_gap(), 1'b0);
      queue_request(OP_CLEAR, $urandom(), pick_gap(), 1'b0);
      for (int i = 0; i < DEPTH; i++)
         queue_request(OP_ADD, 32'h5555_5555, pick_gap(), 1'b0);
      queue_request(OP_ADD, 32'hAAAA_AAAA, pick_gap(), 1'b0);
      queue_request(OP_COUNT, 32'h5555_5555, pick_gap(), 1'b0);

      while (total_reqs < RANDOM_REQS) begin
         pool_n = $urandom_range(1, 8);
         for (int i = 0; i < pool_n; i++) begin
            r = $urandom_range(0, 9);
            pool[i] = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
         end
         case ($urandom_range(0, 2))
            0: add_w = 20;
            1: add_w = 40;
            default: add_w = 60;
         endcase
         quiet = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(60, 160);
         for (int k = 0; k < phase_len && total_reqs < RANDOM_REQS; k++) begin
            r = $urandom_range(0, 99);
            if (r < add_w) op = OP_ADD;
            else if (r < 97) op = $urandom_range(0, 1) ? OP_REMOVE : OP_COUNT;
            else op = OP_CLEAR;
            v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)] : $urandom();
            gap = quiet ? 0 : pick_gap();
            queue_request(op, v, gap, (k == 0) && (total_reqs < 40 || $urandom_range(0, 1)));
         end
      end

      @(negedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (accepted != total_reqs || awaited_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d requests: %0d add (%0d refused when full), %0d remove (%0d absent),",
               accepted, n_add, n_add_full, n_remove, n_remove_miss);
      $display("%0d count (%0d hits), %0d clear; store found full %0d times; %0d mismatches",
               n_count, n_count_hit, n_clear, n_full_seen, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
